### design/aes_pkg.sv
// Shared types, constants and byte-level functions for the AES-128 block encrypt unit.
// Depends on nothing; every other design file imports this package.
package aes_pkg;

  localparam int AES_ROUNDS = 10;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] GF_POLY    = 8'h1B;
  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [4:0] FULL_BLOCK = 5'd16;

  // Register selects: the value of address bit 3, which picks the 64-bit register.
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  valid_bytes;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADDKEY,
    ST_ROUND,
    ST_DONE
  } enc_state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  // Byte i of a 128-bit state sits at bits 127-8i down; byte i is row i%4 of column i/4.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = s[127 - 32 * c -: 8];
      a1  = s[119 - 32 * c -: 8];
      a2  = s[111 - 32 * c -: 8];
      a3  = s[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // One step of the key schedule: the next four words from the previous four.
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] w3, rot, sw, n0, n1, n2, n3;
    w3  = k[31:0];
    rot = {w3[23:0], w3[31:24]};
    sw  = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
    n0  = k[127:96] ^ sw ^ {rcon, 24'h0};
    n1  = k[95:64] ^ n0;
    n2  = k[63:32] ^ n1;
    n3  = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // Bit padding: below sixteen valid bytes, the first invalid byte is 0x80 and later ones zero.
  function automatic logic [127:0] pad_block(input in_item_t it);
    logic [127:0] b;
    b = {it.block_high, it.block_low};
    if (it.valid_bytes < FULL_BLOCK) begin
      for (int j = 0; j < 16; j++) begin
        if (5'(j) == it.valid_bytes) begin
          b[127 - 8 * j -: 8] = PAD_MARK;
        end else if (5'(j) > it.valid_bytes) begin
          b[127 - 8 * j -: 8] = 8'h00;
        end
      end
    end
    return b;
  endfunction

endpackage

### design/aes128_block_encrypt_unit.sv
// Top level of the AES-128 ECB block encrypt unit with bit padding.
// Depends on aes_pkg and aes_round.
//
// The unit encrypts one 16-byte block per request with AES-128. Blocks with fewer than sixteen
// valid bytes are padded: the first invalid byte becomes 0x80 and the rest zero. The key is
// written through the APB port as two 64-bit registers (key_high at byte address 0, key_low at
// byte address 8); pready is always high and reads return the key. The round keys live in an
// eleven-entry by 128-bit memory with a registered read. After reset, and after every key write,
// the key schedule is rebuilt one round key per cycle, during which in_stall is held high. A
// request then goes from acceptance to the output register through the initial key addition
// (the first round key is already read while the unit is idle), one pass per round through the
// shared round unit, and the hand-off. No new request is accepted before the hand-off, but one
// can be accepted while the previous result still waits in the output register. A result held
// in the output register by out_stall delays the hand-off of the next one until it has been
// taken.
module aes128_block_encrypt_unit
  import aes_pkg::*;
#(
  parameter int ROUNDS = AES_ROUNDS
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,

  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int NUM_KEYS = ROUNDS + 1;
  localparam int AW       = $clog2(NUM_KEYS);

  // Round key memory: entry k holds round key k, byte 0 in the top bits.
  logic [127:0] rk_mem [NUM_KEYS];
  logic [127:0] rk_q_r;
  logic [AW-1:0] rd_addr;

  // Configuration registers.
  logic [63:0] key_high_r, key_low_r;
  logic        cfg_write;

  // Key schedule sequencer.
  logic          exp_busy_r, exp_busy_nxt;
  logic [127:0]  exp_key_r, exp_key_nxt;
  logic [7:0]    exp_rcon_r, exp_rcon_nxt;
  logic [AW-1:0] exp_cnt_r, exp_cnt_nxt;

  // Encryption control and datapath.
  enc_state_t    st_r, st_nxt;
  logic [AW-1:0] rnd_r, rnd_nxt;
  logic [127:0]  blk_r, blk_nxt;
  logic [127:0]  round_out;
  logic          last_round;
  logic          in_accept;

  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[3] == REG_KEY_LOW) ? key_low_r : key_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_write) begin
      if (paddr[3] == REG_KEY_HIGH) begin
        key_high_r <= pwdata;
      end else begin
        key_low_r <= pwdata;
      end
    end
  end

  // The schedule restarts from the freshly written key on every write, so a second write that
  // lands during a rebuild still ends with a schedule for the final key.
  always_comb begin
    exp_busy_nxt = exp_busy_r;
    exp_key_nxt  = exp_key_r;
    exp_rcon_nxt = exp_rcon_r;
    exp_cnt_nxt  = exp_cnt_r;
    if (cfg_write) begin
      exp_busy_nxt = 1'b1;
      exp_rcon_nxt = RCON_FIRST;
      exp_cnt_nxt  = '0;
      exp_key_nxt  = (paddr[3] == REG_KEY_HIGH) ? {pwdata, key_low_r} : {key_high_r, pwdata};
    end else if (exp_busy_r) begin
      exp_key_nxt  = key_step(exp_key_r, exp_rcon_r);
      exp_rcon_nxt = xtime(exp_rcon_r);
      exp_cnt_nxt  = exp_cnt_r + AW'(1);
      if (exp_cnt_r == AW'(ROUNDS)) begin
        exp_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_busy_r <= 1'b1;
      exp_key_r  <= '0;
      exp_rcon_r <= RCON_FIRST;
      exp_cnt_r  <= '0;
    end else begin
      exp_busy_r <= exp_busy_nxt;
      exp_key_r  <= exp_key_nxt;
      exp_rcon_r <= exp_rcon_nxt;
      exp_cnt_r  <= exp_cnt_nxt;
    end
  end

  // The schedule writes while new requests stall; a key write during a request is not held off.
  always_ff @(posedge clk) begin
    if (exp_busy_r && !cfg_write) begin
      rk_mem[exp_cnt_r] <= exp_key_r;
    end
    rk_q_r <= rk_mem[rd_addr];
  end

  assign in_stall  = (st_r != ST_IDLE) || exp_busy_r;
  assign in_accept = in_valid && !in_stall;
  assign last_round = (rnd_r == AW'(ROUNDS));

  aes_round u_round (
    .state_in   (blk_r),
    .round_key  (rk_q_r),
    .last_round (last_round),
    .state_out  (round_out)
  );

  // One round per cycle: the key for the next round is read while the current one is applied.
  always_comb begin
    st_nxt        = st_r;
    rnd_nxt       = rnd_r;
    blk_nxt       = blk_r;
    rd_addr       = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (st_r)
      ST_IDLE: begin
        if (in_accept) begin
          blk_nxt = pad_block(in_data);
          st_nxt  = ST_ADDKEY;
        end
      end
      ST_ADDKEY: begin
        blk_nxt = blk_r ^ rk_q_r;
        rd_addr = AW'(1);
        rnd_nxt = AW'(1);
        st_nxt  = ST_ROUND;
      end
      ST_ROUND: begin
        blk_nxt = round_out;
        if (last_round) begin
          st_nxt = ST_DONE;
        end else begin
          rd_addr = rnd_r + AW'(1);
          rnd_nxt = rnd_r + AW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{cipher_high: blk_r[127:64], cipher_low: blk_r[63:0]};
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/aes_round.sv
// One AES round datapath: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// Depends on aes_pkg for the S-box and byte functions.
module aes_round
  import aes_pkg::*;
(
  input  logic [127:0] state_in,
  input  logic [127:0] round_key,
  input  logic         last_round,
  output logic [127:0] state_out
);

  logic [127:0] shifted;
  logic [127:0] mixed;

  always_comb begin
    shifted   = sub_shift(state_in);
    mixed     = mix_cols(shifted);
    // The last round skips the column mix.
    state_out = (last_round ? shifted : mixed) ^ round_key;
  end

endmodule

### design/aes_check.sv
// Port-level checker for the AES-128 block encrypt unit, and its bind to the top level.
// Depends on aes_pkg for the payload types.
module aes_check
  import aes_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data,
  input logic      psel,
  input logic      penable,
  input logic      pwrite
);

  // A result that is held back stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A held-back result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // The unit works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while the previous one is in work");

  // A key write rebuilds the schedule, which holds off requests.
  a_stall_after_key: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite |=> in_stall)
    else $error("request not held off after a key write");

endmodule

bind aes128_block_encrypt_unit aes_check u_aes_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite)
);
